/* sv/hcm_pkg.sv */
package hcm_pkg;

  localparam int ORD_W         = 5;
  localparam int CFG_W         = 4;
  localparam int COORD_W       = 10;
  localparam int ENT_W         = 4;
  localparam int DEF_MAX_ORDER = 10;

  localparam logic [1:0] PAT_A = 2'd0;

  localparam logic [1:0] HEAD_E = 2'd0;
  localparam logic [1:0] HEAD_N = 2'd1;
  localparam logic [1:0] HEAD_W = 2'd2;
  localparam logic [1:0] HEAD_S = 2'd3;

  localparam logic [1:0] PH_LAST_MOVE = 2'd2;

  // sub-pattern entered after each phase, indexed [pattern][phase]
  localparam logic [1:0] SUB_PAT [4][4] = '{
    '{2'd3, 2'd0, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd1, 2'd0},
    '{2'd1, 2'd2, 2'd2, 2'd3},
    '{2'd0, 2'd3, 2'd3, 2'd2}
  };

  // move of each phase, indexed [pattern][phase]; phase three never moves
  localparam logic [1:0] MOVE_DIR [4][4] = '{
    '{HEAD_W, HEAD_S, HEAD_E, HEAD_E},
    '{HEAD_N, HEAD_E, HEAD_S, HEAD_E},
    '{HEAD_E, HEAD_N, HEAD_W, HEAD_E},
    '{HEAD_S, HEAD_W, HEAD_N, HEAD_E}
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_MOVE,
    S_DESC,
    S_FIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         heading;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               last_move;
    logic               exhausted;
  } result_t;

endpackage

/* sv/hcm_out.sv */
module hcm_out
  import hcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    free,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_data
);

  logic    valid_r;
  result_t data_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      data_r <= load_data;
    end
  end

endmodule

/* sv/hilbert_curve_move_generator_unit.sv */
// Hilbert curve move generator.
// Config: cfg_wr_en/cfg_wr_data write the curve order (0 acts as 1, values
// above MAX_ORDER act as MAX_ORDER); write only while the block is idle.
// Input channel (in_valid/in_ready, in_restart): each transaction asks for
// one move. in_restart=1 starts a new walk at the top-right cell and gives
// its first move; in_restart=0 gives the next move.
// Output channel (out_valid/out_ready): one transaction per input, carrying
// heading, pos_x, pos_y after the move, last_move on the final move, or
// out_exhausted with all other fields zero once no move remains.
// A move pops finished levels, reads and advances the top level, pushes
// child levels back up to the order, then loads the result; a restart
// first pushes levels from the root up to the order, then makes its move.
// The per-level pattern/phase stack lives in a synchronous memory with a
// registered read. An exhausted reply skips the move and the pushes.
// One item is in work at a time; in_ready is high only between items.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; the block waits before loading another result.
// Reset: order 1, no walk started (moves return exhausted until a restart),
// output empty.
module hilbert_curve_move_generator_unit
  import hcm_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_heading,
  output logic [COORD_W-1:0] out_pos_x,
  output logic [COORD_W-1:0] out_pos_y,
  output logic               out_last_move,
  output logic               out_exhausted
);

  localparam int LVL_W = $clog2(MAX_ORDER + 1);
  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     curve_order_r;
  logic [LVL_W-1:0]     level_r, level_nxt;
  logic [COORD_W-1:0]   cur_x_r, cur_x_nxt;
  logic [COORD_W-1:0]   cur_y_r, cur_y_nxt;
  logic                 walk_done_r, walk_done_nxt;
  logic [ENT_W-1:0]     top_r, top_nxt;
  logic                 moved_r, moved_nxt;
  logic [1:0]           head_r, head_nxt;
  logic                 last_r, last_nxt;
  logic                 exh_r, exh_nxt;
  logic [MAX_ORDER-1:0] done_r, done_nxt;

  logic [ENT_W-1:0]     stack_mem [MAX_ORDER];
  logic [ENT_W-1:0]     rd_data_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;
  logic                 rd_en;

  logic [ORD_W-1:0]     ord_ext;
  logic [ORD_W-1:0]     eff_order;
  logic [ORD_W-1:0]     lvl_ext;
  logic [LVL_W-1:0]     lvl_m1;
  logic [IDX_W-1:0]     top_idx;
  logic [IDX_W-1:0]     push_idx;
  logic [COORD_W-1:0]   start_xy;
  logic [MAX_ORDER-1:0] below;
  logic                 all_last;
  logic [1:0]           pat, ph, mv;
  logic [ENT_W-1:0]     child;

  logic                 load;
  logic                 out_free;
  result_t              load_data;
  result_t              out_data;

  assign ord_ext   = ORD_W'(curve_order_r);
  assign eff_order = (ord_ext == '0) ? ORD_W'(1) :
                     (ord_ext > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ord_ext;
  assign lvl_ext   = ORD_W'(level_r);
  assign lvl_m1    = level_r - LVL_W'(1);
  assign top_idx   = lvl_m1[IDX_W-1:0];
  assign push_idx  = level_r[IDX_W-1:0];
  assign start_xy  = ~({COORD_W{1'b1}} << eff_order);

  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      below[i] = (LVL_W'(i) < level_r);
    end
  end

  assign all_last = &(done_r | ~below);
  assign pat      = rd_data_r[3:2];
  assign ph       = rd_data_r[1:0];
  assign mv       = MOVE_DIR[pat][ph];
  assign child    = {SUB_PAT[top_r[3:2]][top_r[1:0]], 2'b00};
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    walk_done_nxt = walk_done_r;
    top_nxt       = top_r;
    moved_nxt     = moved_r;
    head_nxt      = head_r;
    last_nxt      = last_r;
    exh_nxt       = exh_r;
    done_nxt      = done_r;
    mem_we        = 1'b0;
    mem_waddr     = top_idx;
    mem_wdata     = top_r;
    rd_en         = 1'b0;
    load          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          moved_nxt = 1'b0;
          if (in_restart) begin
            cur_x_nxt     = start_xy;
            cur_y_nxt     = start_xy;
            mem_we        = 1'b1;
            mem_waddr     = '0;
            mem_wdata     = {PAT_A, 2'b00};
            done_nxt[0]   = 1'b0;
            level_nxt     = LVL_W'(1);
            walk_done_nxt = 1'b0;
            top_nxt       = {PAT_A, 2'b00};
            state_nxt     = S_DESC;
          end else if (walk_done_r) begin
            exh_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (level_r == '0) begin
          walk_done_nxt = 1'b1;
          exh_nxt       = 1'b1;
          state_nxt     = S_EMIT;
        end else if (done_r[top_idx]) begin
          level_nxt = lvl_m1;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        mem_we            = 1'b1;
        mem_waddr         = top_idx;
        mem_wdata         = {pat, ph + 2'd1};
        done_nxt[top_idx] = (ph == PH_LAST_MOVE);
        top_nxt           = {pat, ph + 2'd1};
        head_nxt          = mv;
        moved_nxt         = 1'b1;
        case (mv)
          HEAD_E:  cur_x_nxt = cur_x_r + COORD_W'(1);
          HEAD_W:  cur_x_nxt = cur_x_r - COORD_W'(1);
          HEAD_N:  cur_y_nxt = cur_y_r + COORD_W'(1);
          default: cur_y_nxt = cur_y_r - COORD_W'(1);
        endcase
        state_nxt = S_DESC;
      end
      S_DESC: begin
        if (lvl_ext < eff_order) begin
          mem_we             = 1'b1;
          mem_waddr          = push_idx;
          mem_wdata          = child;
          done_nxt[push_idx] = 1'b0;
          level_nxt          = level_r + LVL_W'(1);
          top_nxt            = child;
        end else begin
          state_nxt = moved_r ? S_FIN : S_POP;
        end
      end
      S_FIN: begin
        last_nxt      = all_last;
        walk_done_nxt = all_last;
        exh_nxt       = 1'b0;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        load = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      curve_order_r <= CFG_W'(1);
      level_r       <= '0;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      walk_done_r   <= 1'b1;
      moved_r       <= 1'b0;
      exh_r         <= 1'b0;
      done_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      walk_done_r <= walk_done_nxt;
      moved_r     <= moved_nxt;
      exh_r       <= exh_nxt;
      done_r      <= done_nxt;
      if (cfg_wr_en) begin
        curve_order_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    head_r <= head_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[top_idx];
    end
  end

  always_comb begin
    if (exh_r) begin
      load_data           = '0;
      load_data.exhausted = 1'b1;
    end else begin
      load_data.heading   = head_r;
      load_data.pos_x     = cur_x_r;
      load_data.pos_y     = cur_y_r;
      load_data.last_move = last_r;
      load_data.exhausted = 1'b0;
    end
  end

  hcm_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (load_data),
    .free      (out_free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_heading   = out_data.heading;
  assign out_pos_x     = out_data.pos_x;
  assign out_pos_y     = out_data.pos_y;
  assign out_last_move = out_data.last_move;
  assign out_exhausted = out_data.exhausted;

endmodule

/* sv/hcm_check.sv */
module hcm_check
  import hcm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_heading,
  input logic [COORD_W-1:0] out_pos_x,
  input logic [COORD_W-1:0] out_pos_y,
  input logic               out_last_move,
  input logic               out_exhausted
);

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading) &&
      $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_last_move) &&
      $stable(out_exhausted))
    else $error("stalled result changed");

  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_heading == 2'd0 && out_pos_x == '0 &&
      out_pos_y == '0 && !out_last_move)
    else $error("exhausted result carries data");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind hilbert_curve_move_generator_unit hcm_check u_hcm_check (.*);
